// ===== rtl/core/im2cag_pkg.sv =====
package im2cag_pkg;

  localparam int INDEX_WIDTH_DEF = 16;
  localparam int ADDR_WIDTH_DEF  = 32;

  localparam int WORD_ADDR_W = 32;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 32;

  localparam int DIM_W  = 8;
  localparam int SPAN_W = 16;
  localparam int PS_W   = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_DIMS  = 4'd0,
    REG_PAD_W        = 4'd1,
    REG_PAD_H        = 4'd2,
    REG_STRIDE_W     = 4'd3,
    REG_STRIDE_H     = 4'd4,
    REG_OUT_WIDTH    = 4'd5,
    REG_ROW_STRIDE   = 4'd6,
    REG_PLANE_STRIDE = 4'd7
  } cfg_reg_t;

endpackage

// ===== rtl/core/im2col_address_generator_top.sv =====
// Path: input register, three division pipelines, stages m1 to m4, then the output register.
// Throughput: one word per cycle unless out_ready holds the output; the three bit-per-stage
// division pipelines (pixel by output width, kernel index by kernel area, remainder by kernel
// width) set the depth, and every stage advances together under one enable.
// Reset: synchronous, active low; clears all valid bits and loads register defaults.
module im2col_address_generator_top #(
  parameter int INDEX_WIDTH = im2cag_pkg::INDEX_WIDTH_DEF,
  parameter int ADDR_WIDTH  = im2cag_pkg::ADDR_WIDTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [INDEX_WIDTH-1:0]               in_kernel_index,
  input  logic [INDEX_WIDTH-1:0]               in_pixel_index,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [im2cag_pkg::WORD_ADDR_W-1:0]   out_word_address,
  output logic                                 out_padded,
  input  logic                                 cfg_we,
  input  logic [im2cag_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [im2cag_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int DIM_W    = im2cag_pkg::DIM_W;
  localparam int SPAN_W   = im2cag_pkg::SPAN_W;
  localparam int PS_W     = im2cag_pkg::PS_W;
  localparam int PRODW_W  = SPAN_W + DIM_W;
  localparam int COL_W    = PRODW_W + 2;
  localparam int PRODH_W  = INDEX_WIDTH + DIM_W;
  localparam int ROWPOS_W = PRODH_W + 2;
  localparam int ROFF_W   = ROWPOS_W + SPAN_W;
  localparam int PP_W     = INDEX_WIDTH + PS_W;
  localparam int R_SIDE_W = 2 * INDEX_WIDTH + SPAN_W;

  // configuration
  logic [DIM_W-1:0]  kw_r;
  logic [DIM_W-1:0]  kh_r;
  logic [DIM_W-1:0]  pad_w_r;
  logic [DIM_W-1:0]  pad_h_r;
  logic [DIM_W-1:0]  stride_w_r;
  logic [DIM_W-1:0]  stride_h_r;
  logic [SPAN_W-1:0] ow_r;
  logic [SPAN_W-1:0] row_stride_r;
  logic [PS_W-1:0]   plane_stride_r;
  logic [SPAN_W-1:0] area_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kw_r           <= DIM_W'(3);
      kh_r           <= DIM_W'(3);
      pad_w_r        <= '0;
      pad_h_r        <= '0;
      stride_w_r     <= DIM_W'(1);
      stride_h_r     <= DIM_W'(1);
      ow_r           <= SPAN_W'(1);
      row_stride_r   <= SPAN_W'(1);
      plane_stride_r <= PS_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        im2cag_pkg::REG_KERNEL_DIMS: begin
          kw_r <= (cfg_wdata[7:0] == '0) ? DIM_W'(1) : cfg_wdata[7:0];
          kh_r <= (cfg_wdata[15:8] == '0) ? DIM_W'(1) : cfg_wdata[15:8];
        end
        im2cag_pkg::REG_PAD_W:        pad_w_r    <= cfg_wdata[DIM_W-1:0];
        im2cag_pkg::REG_PAD_H:        pad_h_r    <= cfg_wdata[DIM_W-1:0];
        im2cag_pkg::REG_STRIDE_W:     stride_w_r <= cfg_wdata[DIM_W-1:0];
        im2cag_pkg::REG_STRIDE_H:     stride_h_r <= cfg_wdata[DIM_W-1:0];
        im2cag_pkg::REG_OUT_WIDTH: begin
          ow_r <= (cfg_wdata[SPAN_W-1:0] == '0) ? SPAN_W'(1) : cfg_wdata[SPAN_W-1:0];
        end
        im2cag_pkg::REG_ROW_STRIDE:   row_stride_r   <= cfg_wdata[SPAN_W-1:0];
        im2cag_pkg::REG_PLANE_STRIDE: plane_stride_r <= cfg_wdata[PS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      area_r <= SPAN_W'(9);
    end else begin
      area_r <= SPAN_W'(kw_r) * SPAN_W'(kh_r);
    end
  end

  // flow control
  logic en;
  logic out_vld_r;

  assign en       = !out_vld_r || out_ready;

  // input register
  logic                   s0_vld_r;
  logic [INDEX_WIDTH-1:0] s0_kidx_r;
  logic [INDEX_WIDTH-1:0] s0_pidx_r;
  logic                   load;

  assign in_ready = en || !s0_vld_r;
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= load || (s0_vld_r && !en);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      s0_kidx_r <= in_kernel_index;
      s0_pidx_r <= in_pixel_index;
    end
  end

  // pixel split: output row and column
  logic                   p_vld;
  logic [INDEX_WIDTH-1:0] p_orow;
  logic [SPAN_W-1:0]      p_ocol;
  logic [INDEX_WIDTH-1:0] p_kidx;

  im2cag_div_pipe #(
    .NUM_W  (INDEX_WIDTH),
    .DEN_W  (SPAN_W),
    .SIDE_W (INDEX_WIDTH)
  ) u_div_pixel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s0_vld_r),
    .in_num    (s0_pidx_r),
    .in_rem    ('0),
    .den       (ow_r),
    .in_side   (s0_kidx_r),
    .out_valid (p_vld),
    .out_quo   (p_orow),
    .out_rem   (p_ocol),
    .out_side  (p_kidx)
  );

  // kernel split: plane and in-plane remainder
  logic                            k_vld;
  logic [INDEX_WIDTH-1:0]          k_plane;
  logic [SPAN_W-1:0]               k_rest;
  logic [INDEX_WIDTH+SPAN_W-1:0]   k_side;

  im2cag_div_pipe #(
    .NUM_W  (INDEX_WIDTH),
    .DEN_W  (SPAN_W),
    .SIDE_W (INDEX_WIDTH + SPAN_W)
  ) u_div_plane (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (p_vld),
    .in_num    (p_kidx),
    .in_rem    ('0),
    .den       (area_r),
    .in_side   ({p_orow, p_ocol}),
    .out_valid (k_vld),
    .out_quo   (k_plane),
    .out_rem   (k_rest),
    .out_side  (k_side)
  );

  // remainder split: kernel row and column; the row fits in eight bits
  logic                r_vld;
  logic [DIM_W-1:0]    r_krow;
  logic [DIM_W-1:0]    r_kcol;
  logic [R_SIDE_W-1:0] r_side;
  logic [INDEX_WIDTH-1:0] r_plane;
  logic [INDEX_WIDTH-1:0] r_orow;
  logic [SPAN_W-1:0]      r_ocol;

  im2cag_div_pipe #(
    .NUM_W  (DIM_W),
    .DEN_W  (DIM_W),
    .SIDE_W (R_SIDE_W)
  ) u_div_kernel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (k_vld),
    .in_num    (k_rest[DIM_W-1:0]),
    .in_rem    (k_rest[SPAN_W-1:DIM_W]),
    .den       (kw_r),
    .in_side   ({k_plane, k_side}),
    .out_valid (r_vld),
    .out_quo   (r_krow),
    .out_rem   (r_kcol),
    .out_side  (r_side)
  );

  assign {r_plane, r_orow, r_ocol} = r_side;

  // stage m1: products
  logic                  m1_vld_r;
  logic [PRODW_W-1:0]    m1_prod_w_r;
  logic [PRODH_W-1:0]    m1_prod_h_r;
  logic [ADDR_WIDTH-1:0] m1_pp_r;
  logic [DIM_W-1:0]      m1_krow_r;
  logic [DIM_W-1:0]      m1_kcol_r;
  logic [PRODW_W-1:0]    m1_prod_w_nxt;
  logic [PRODH_W-1:0]    m1_prod_h_nxt;
  logic [PP_W-1:0]       pp_full;

  assign m1_prod_w_nxt = PRODW_W'(r_ocol) * PRODW_W'(stride_w_r);
  assign m1_prod_h_nxt = PRODH_W'(r_orow) * PRODH_W'(stride_h_r);
  assign pp_full       = PP_W'(r_plane) * PP_W'(plane_stride_r);

  // stage m2: signed positions
  logic                        m2_vld_r;
  logic signed [COL_W-1:0]     m2_col_r;
  logic signed [ROWPOS_W-1:0]  m2_rowpos_r;
  logic [ADDR_WIDTH-1:0]       m2_pp_r;
  logic signed [COL_W-1:0]     m2_col_nxt;
  logic signed [ROWPOS_W-1:0]  m2_rowpos_nxt;

  assign m2_col_nxt = $signed(COL_W'(m1_kcol_r)) - $signed(COL_W'(pad_w_r))
                    + $signed(COL_W'(m1_prod_w_r));
  assign m2_rowpos_nxt = $signed(ROWPOS_W'(m1_krow_r)) - $signed(ROWPOS_W'(pad_h_r))
                       + $signed(ROWPOS_W'(m1_prod_h_r));

  // stage m3: row offset, column bound
  logic                      m3_vld_r;
  logic signed [ROFF_W-1:0]  m3_roff_r;
  logic                      m3_col_bad_r;
  logic [SPAN_W-1:0]         m3_col_r;
  logic [ADDR_WIDTH-1:0]     m3_pp_r;
  logic signed [ROFF_W-1:0]  m3_roff_nxt;
  logic                      m3_col_bad_nxt;

  assign m3_roff_nxt    = ROFF_W'(m2_rowpos_r) * ROFF_W'($signed({1'b0, row_stride_r}));
  assign m3_col_bad_nxt = m2_col_r[COL_W-1]
                       || ($unsigned(m2_col_r) >= COL_W'(row_stride_r));

  // stage m4: row bound, partial address
  logic                  m4_vld_r;
  logic                  m4_pad_r;
  logic [ADDR_WIDTH-1:0] m4_part_r;
  logic [PS_W-1:0]       m4_roff_r;
  logic                  m4_pad_nxt;

  assign m4_pad_nxt = m3_col_bad_r || m3_roff_r[ROFF_W-1]
                   || ($unsigned(m3_roff_r) >= ROFF_W'(plane_stride_r));

  // output register
  logic [im2cag_pkg::WORD_ADDR_W-1:0] out_addr_r;
  logic                               out_pad_r;
  logic [ADDR_WIDTH-1:0]              addr_nxt;

  assign addr_nxt = m4_part_r + ADDR_WIDTH'(m4_roff_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_vld_r  <= 1'b0;
      m2_vld_r  <= 1'b0;
      m3_vld_r  <= 1'b0;
      m4_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (en) begin
      m1_vld_r  <= r_vld;
      m2_vld_r  <= m1_vld_r;
      m3_vld_r  <= m2_vld_r;
      m4_vld_r  <= m3_vld_r;
      out_vld_r <= m4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_prod_w_r  <= m1_prod_w_nxt;
      m1_prod_h_r  <= m1_prod_h_nxt;
      m1_pp_r      <= ADDR_WIDTH'(pp_full);
      m1_krow_r    <= r_krow;
      m1_kcol_r    <= r_kcol;
      m2_col_r     <= m2_col_nxt;
      m2_rowpos_r  <= m2_rowpos_nxt;
      m2_pp_r      <= m1_pp_r;
      m3_roff_r    <= m3_roff_nxt;
      m3_col_bad_r <= m3_col_bad_nxt;
      m3_col_r     <= m2_col_r[SPAN_W-1:0];
      m3_pp_r      <= m2_pp_r;
      m4_pad_r     <= m4_pad_nxt;
      m4_part_r    <= m3_pp_r + ADDR_WIDTH'(m3_col_r);
      m4_roff_r    <= m3_roff_r[PS_W-1:0];
      out_pad_r    <= m4_pad_r;
      out_addr_r   <= m4_pad_r ? '0 : im2cag_pkg::WORD_ADDR_W'(addr_nxt);
    end
  end

  assign out_valid        = out_vld_r;
  assign out_word_address = out_addr_r;
  assign out_padded       = out_pad_r;

  // hold the input word while the pipe is frozen
  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    s0_vld_r && !en |=> s0_vld_r)
    else $error("input word dropped during stall");

  // advance the last stage into the output register
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && m4_vld_r |=> out_vld_r)
    else $error("result lost between last stage and output");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_padded |-> out_word_address == '0)
    else $error("padded word carries a non-zero address");

endmodule

// ===== rtl/core/im2cag_div_pipe.sv =====
module im2cag_div_pipe #(
  parameter int NUM_W  = im2cag_pkg::INDEX_WIDTH_DEF,
  parameter int DEN_W  = im2cag_pkg::SPAN_W,
  parameter int SIDE_W = im2cag_pkg::INDEX_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_rem,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [NUM_W-1:0]  out_quo,
  output logic [DEN_W-1:0]  out_rem,
  output logic [SIDE_W-1:0] out_side
);

  logic [NUM_W-1:0]  vld_r;
  logic [DEN_W-1:0]  rem_r  [NUM_W];
  logic [NUM_W-1:0]  num_r  [NUM_W];
  logic [SIDE_W-1:0] side_r [NUM_W];

  // one quotient bit per stage, numerator shifts out as quotient shifts in
  for (genvar k = 0; k < NUM_W; k++) begin : g_step
    logic              vld_in;
    logic [DEN_W-1:0]  rem_in;
    logic [NUM_W-1:0]  num_in;
    logic [SIDE_W-1:0] side_in;
    logic [DEN_W:0]    trial;
    logic              take;

    if (k == 0) begin : g_head
      assign vld_in  = in_valid;
      assign rem_in  = in_rem;
      assign num_in  = in_num;
      assign side_in = in_side;
    end else begin : g_tail
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign num_in  = num_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign trial = {rem_in, num_in[NUM_W-1]};
    assign take  = (trial >= {1'b0, den});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        num_r[k]  <= {num_in[NUM_W-2:0], take};
        side_r[k] <= side_in;
      end
    end
  end

  assign out_valid = vld_r[NUM_W-1];
  assign out_quo   = num_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_side  = side_r[NUM_W-1];

endmodule

// ===== dv/im2col_address_generator_top_tb.sv =====
`timescale 1ns / 1ps

module im2col_address_generator_top_tb;

  localparam int IDX_W       = im2cag_pkg::INDEX_WIDTH_DEF;
  localparam int ADDR_W      = im2cag_pkg::ADDR_WIDTH_DEF;
  localparam int WORD_ADDR_W = im2cag_pkg::WORD_ADDR_W;
  localparam int CFG_IDX_W   = im2cag_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = im2cag_pkg::CFG_DATA_W;
  localparam int DIM_W       = im2cag_pkg::DIM_W;
  localparam int SPAN_W      = im2cag_pkg::SPAN_W;
  localparam int PS_W        = im2cag_pkg::PS_W;
  localparam int PIPE_DEPTH  = 2 * IDX_W + 13;
  localparam int CYCLE_LIMIT = 200000;
  localparam int REPORT_MAX  = 10;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_FIRST = 4'd8;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LAST  = 4'd15;

  typedef struct {
    logic [IDX_W-1:0]       kidx;
    logic [IDX_W-1:0]       pidx;
    logic [WORD_ADDR_W-1:0] addr;
    logic                   padded;
  } operand_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [IDX_W-1:0]       in_kernel_index = '0;
  logic [IDX_W-1:0]       in_pixel_index = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [WORD_ADDR_W-1:0] out_word_address;
  logic                   out_padded;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  logic [SPAN_W-1:0] kernel_dims  = 16'h0303;
  logic [DIM_W-1:0]  pad_w        = 8'd0;
  logic [DIM_W-1:0]  pad_h        = 8'd0;
  logic [DIM_W-1:0]  stride_w     = 8'd1;
  logic [DIM_W-1:0]  stride_h     = 8'd1;
  logic [SPAN_W-1:0] out_width    = 16'd1;
  logic [SPAN_W-1:0] row_stride   = 16'd1;
  logic [PS_W-1:0]   plane_stride = 32'd1;

  operand_t pending_operands[$];
  int       failures    = 0;
  int       cycle_count = 0;
  int       stall_left  = 0;
  int       kidx_span   = 65535;
  int       pidx_span   = 65535;
  bit       src_idle_on = 1'b0;
  bit       snk_idle_on = 1'b0;

  im2col_address_generator_top u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_kernel_index  (in_kernel_index),
    .in_pixel_index   (in_pixel_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_word_address (out_word_address),
    .out_padded       (out_padded),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_operands.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic operand_t locate_operand(input logic [IDX_W-1:0] kidx,
                                              input logic [IDX_W-1:0] pidx);
    operand_t          op;
    longint unsigned   kw, kh, ow, area, plane, rest, krow, kcol, orow, ocol, sum;
    longint            col, row, roff;
    op.kidx = kidx;
    op.pidx = pidx;
    kw = kernel_dims[7:0];
    kh = kernel_dims[15:8];
    ow = out_width;
    if (kw == 0) kw = 1;
    if (kh == 0) kh = 1;
    if (ow == 0) ow = 1;
    area  = kw * kh;
    plane = kidx / area;
    rest  = kidx % area;
    krow  = rest / kw;
    kcol  = rest % kw;
    orow  = pidx / ow;
    ocol  = pidx % ow;
    col  = longint'(kcol) - longint'(pad_w) + longint'(ocol * stride_w);
    row  = longint'(krow) - longint'(pad_h) + longint'(orow * stride_h);
    roff = row * longint'(row_stride);
    op.padded = (roff < 0) || ($unsigned(roff) >= plane_stride) ||
                (col < 0) || ($unsigned(col) >= row_stride);
    if (op.padded) begin
      op.addr = '0;
    end else begin
      sum = plane * plane_stride + $unsigned(roff) + $unsigned(col);
      op.addr = WORD_ADDR_W'(sum & ((64'd1 << ADDR_W) - 1));
    end
    return op;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_operands.size() == 0) begin
        failures++;
        if (failures <= REPORT_MAX)
          $display("%0t: unexpected word addr %h padded %b", $realtime,
                   out_word_address, out_padded);
      end else begin
        operand_t op;
        op = pending_operands.pop_front();
        if (out_word_address !== op.addr || out_padded !== op.padded) begin
          failures++;
          if (failures <= REPORT_MAX)
            $display("%0t: k=%h p=%h expected addr %h padded %b, got addr %h padded %b",
                     $realtime, op.kidx, op.pidx, op.addr, op.padded,
                     out_word_address, out_padded);
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (snk_idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic issue_position(input logic [IDX_W-1:0] kidx, input logic [IDX_W-1:0] pidx);
    if (src_idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_kernel_index <= kidx;
    in_pixel_index  <= pidx;
    do @(posedge clk); while (!in_ready);
    pending_operands.push_back(locate_operand(kidx, pidx));
  endtask

  task automatic drain_operands();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_operands.size() != 0);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      im2cag_pkg::REG_KERNEL_DIMS:  kernel_dims  = data[SPAN_W-1:0];
      im2cag_pkg::REG_PAD_W:        pad_w        = data[DIM_W-1:0];
      im2cag_pkg::REG_PAD_H:        pad_h        = data[DIM_W-1:0];
      im2cag_pkg::REG_STRIDE_W:     stride_w     = data[DIM_W-1:0];
      im2cag_pkg::REG_STRIDE_H:     stride_h     = data[DIM_W-1:0];
      im2cag_pkg::REG_OUT_WIDTH:    out_width    = data[SPAN_W-1:0];
      im2cag_pkg::REG_ROW_STRIDE:   row_stride   = data[SPAN_W-1:0];
      im2cag_pkg::REG_PLANE_STRIDE: plane_stride = data[PS_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_geometry(input logic [SPAN_W-1:0] kd, input logic [DIM_W-1:0] pw,
                               input logic [DIM_W-1:0] ph, input logic [DIM_W-1:0] sw,
                               input logic [DIM_W-1:0] sh, input logic [SPAN_W-1:0] ow,
                               input logic [SPAN_W-1:0] rs, input logic [PS_W-1:0] ps);
    drain_operands();
    write_reg(im2cag_pkg::REG_KERNEL_DIMS, CFG_DATA_W'(kd));
    write_reg(im2cag_pkg::REG_PAD_W, CFG_DATA_W'(pw));
    write_reg(im2cag_pkg::REG_PAD_H, CFG_DATA_W'(ph));
    write_reg(im2cag_pkg::REG_STRIDE_W, CFG_DATA_W'(sw));
    write_reg(im2cag_pkg::REG_STRIDE_H, CFG_DATA_W'(sh));
    write_reg(im2cag_pkg::REG_OUT_WIDTH, CFG_DATA_W'(ow));
    write_reg(im2cag_pkg::REG_ROW_STRIDE, CFG_DATA_W'(rs));
    write_reg(im2cag_pkg::REG_PLANE_STRIDE, CFG_DATA_W'(ps));
  endtask

  task automatic pick_geometry(input bit broad);
    int kw, kh, pw, ph, sw, sh, in_w, in_h, ow, oh, ch;
    if (broad) begin
      drain_operands();
      for (int r = im2cag_pkg::REG_KERNEL_DIMS; r <= im2cag_pkg::REG_PLANE_STRIDE; r++)
        write_reg(CFG_IDX_W'(r), $urandom);
      write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_FIRST, REG_UNMAPPED_LAST)), $urandom);
      kidx_span = 65535;
      pidx_span = 65535;
    end else begin
      kw   = $urandom_range(1, 5);
      kh   = $urandom_range(1, 5);
      pw   = $urandom_range(0, kw - 1);
      ph   = $urandom_range(0, kh - 1);
      sw   = $urandom_range(1, 3);
      sh   = $urandom_range(1, 3);
      in_w = $urandom_range(kw, 24);
      in_h = $urandom_range(kh, 24);
      ch   = $urandom_range(1, 6);
      ow   = (in_w + 2 * pw - kw) / sw + 1;
      oh   = (in_h + 2 * ph - kh) / sh + 1;
      load_geometry({8'(kh), 8'(kw)}, 8'(pw), 8'(ph), 8'(sw), 8'(sh), 16'(ow),
                    16'(in_w), 32'(in_w * in_h));
      kidx_span = ch * kw * kh - 1;
      pidx_span = ow * oh - 1;
    end
  endtask

  function automatic logic [IDX_W-1:0] draw_index(input int span);
    if ($urandom_range(0, 6) == 0) return IDX_W'($urandom);
    return IDX_W'($urandom_range(0, span));
  endfunction

  task automatic test_reset_defaults();
    issue_position(16'd0, 16'd0);
    issue_position(16'd3, 16'd0);
    issue_position(16'hFFFF, 16'hFFFF);
    issue_position(16'd0, 16'hFFFF);
  endtask

  task automatic test_field_extremes();
    load_geometry(16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    issue_position(16'd0, 16'd0);
    issue_position(16'hFFFF, 16'hFFFF);
    issue_position(16'h5555, 16'hAAAA);
    issue_position(16'hAAAA, 16'h5555);
    load_geometry(16'h0101, 8'd0, 8'd0, 8'd1, 8'd1, 16'd256, 16'd256, 32'h0001_0000);
    issue_position(16'd0, 16'd0);
    issue_position(16'hFFFF, 16'hFFFF);
  endtask

  task automatic test_degenerate_registers();
    // zero kernel size and output width act as one, zero steps stay zero
    load_geometry(16'h0000, 8'd0, 8'd0, 8'd0, 8'd0, 16'd0, 16'd16, 32'd256);
    issue_position(16'd5, 16'd9);
    issue_position(16'd0, 16'hFFFF);
    load_geometry(16'h0303, 8'd1, 8'd1, 8'd1, 8'd1, 16'd4, 16'd0, 32'd100);
    issue_position(16'd4, 16'd5);
    issue_position(16'd0, 16'd0);
    load_geometry(16'h0303, 8'd0, 8'd0, 8'd1, 8'd1, 16'd4, 16'd8, 32'd0);
    issue_position(16'd4, 16'd5);
    issue_position(16'd0, 16'd0);
    drain_operands();
    write_reg(REG_UNMAPPED_FIRST, '1);
    write_reg(REG_UNMAPPED_LAST, '1);
    write_reg(im2cag_pkg::REG_PLANE_STRIDE, 32'd64);
    write_reg(im2cag_pkg::REG_PAD_W, 32'hFFFF_FF00);
    issue_position(16'd4, 16'd5);
    issue_position(16'd1, 16'd2);
  endtask

  task automatic test_address_wrap();
    load_geometry(16'h0101, 8'd0, 8'd0, 8'd1, 8'd1, 16'd1, 16'hFFFF, 32'hFFFF_FFFF);
    issue_position(16'hFFFF, 16'd0);
    issue_position(16'hFFFF, 16'hFFFF);
    issue_position(16'd1, 16'hFFFF);
  endtask

  task automatic test_random_geometry();
    for (int phase = 0; phase < 8; phase++) begin
      pick_geometry(phase % 4 == 3);
      src_idle_on = ($urandom_range(0, 3) != 0);
      snk_idle_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 40; n++) begin
        // hold the feed until the pipe has emptied
        if (phase == 2 && n == 20) drain_operands();
        issue_position(draw_index(kidx_span), draw_index(pidx_span));
      end
    end
  endtask

  task automatic test_streaming();
    pick_geometry(1'b0);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    for (int n = 0; n < 60; n++)
      issue_position(draw_index(kidx_span), draw_index(pidx_span));
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    test_reset_defaults();
    test_field_extremes();
    test_degenerate_registers();
    test_address_wrap();
    test_random_geometry();
    test_streaming();
    drain_operands();
    repeat (PIPE_DEPTH + 20) @(posedge clk);
    if (failures == 0 && pending_operands.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Mismatches: %0d, words outstanding: %0d", failures, pending_operands.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
